// File: rtl/core/rcpd_pkg.sv
// Shared types and constants for the RC pulse to motor and servo drive unit.
// Holds the stage structs, the fixed pulse and angle limits and the reciprocal
// constants used by the duty and angle maps. No dependencies.
package rcpd_pkg;

  localparam int PULSE_W = 12;
  localparam int BATT_W  = 10;
  localparam int SUM_W   = 16;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Pulse map limits in microseconds.
  localparam logic [PULSE_W-1:0] THR_NEUTRAL = 12'd1470;
  localparam logic [PULSE_W-1:0] THR_MIN     = 12'd975;
  localparam logic [PULSE_W-1:0] THR_MAX     = 12'd1967;
  localparam logic [PULSE_W-1:0] STR_NEUTRAL = 12'd1410;
  localparam logic [PULSE_W-1:0] STR_MIN     = 12'd1000;
  localparam logic [PULSE_W-1:0] STR_MAX     = 12'd1946;

  localparam logic [7:0] ANGLE_MAX    = 8'd140;
  localparam logic [7:0] ANGLE_MIN    = 8'd40;
  localparam logic [7:0] ANGLE_CENTER = 8'd90;
  localparam logic [7:0] ANGLE_SPAN   = 8'd100;

  localparam logic [7:0] CAP_CRIT = 8'd0;
  localparam logic [7:0] CAP_WARN = 8'd200;
  localparam logic [7:0] CAP_LOW  = 8'd50;
  localparam logic [7:0] CAP_FULL = 8'd255;

  localparam logic [CNT_W-1:0] SEND_LIMIT = 4'd10;

  localparam logic [1:0] LED_OFF    = 2'd0;
  localparam logic [1:0] LED_STEADY = 2'd1;
  localparam logic [1:0] LED_BLINK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MOTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STR_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_WARN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_CRIT    = 3'd5;

  localparam logic [BATT_W-1:0] BATT_WARN_RST = 10'd737;
  localparam logic [BATT_W-1:0] BATT_LOW_RST  = 10'd696;
  localparam logic [BATT_W-1:0] BATT_CRIT_RST = 10'd655;
  localparam logic [7:0]        DEADBAND_RST  = 8'd30;

  // Constant divisions are done as multiply by a rounded-up reciprocal with the
  // scale factor folded in. The shift is wide enough to be exact for every
  // dividend the maps can produce (below 2^20 for throttle, 2^19 for steering).
  localparam int RECIP_SHIFT = 29;
  localparam int THR_K_W = 29;
  localparam int STR_K_W = 26;

  localparam longint REV_DIV = longint'(THR_NEUTRAL - THR_MIN);
  localparam longint FWD_DIV = longint'(THR_MAX - THR_NEUTRAL);
  localparam longint STR_DIV = longint'(STR_MAX - STR_MIN);

  localparam logic [THR_K_W-1:0] REV_K =
    THR_K_W'((((64'd1 << RECIP_SHIFT) + REV_DIV - 1) / REV_DIV) * longint'(CAP_FULL));
  localparam logic [THR_K_W-1:0] FWD_K =
    THR_K_W'((((64'd1 << RECIP_SHIFT) + FWD_DIV - 1) / FWD_DIV) * longint'(CAP_FULL));
  localparam logic [STR_K_W-1:0] STR_K =
    STR_K_W'((((64'd1 << RECIP_SHIFT) + STR_DIV - 1) / STR_DIV) * longint'(ANGLE_SPAN));

  typedef struct packed {
    logic              invert_motor;
    logic [7:0]        throttle_deadband;
    logic [7:0]        steering_deadband;
    logic [BATT_W-1:0] battery_warn_raw;
    logic [BATT_W-1:0] battery_low_raw;
    logic [BATT_W-1:0] battery_critical_raw;
  } cfg_t;

  // Front stage result: updated ring sum plus the fields carried along.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic               thr_nz;
    logic [PULSE_W-1:0] str;
    logic [7:0]         cap_prev;
    logic [1:0]         led;
  } front_t;

  // Middle stage result: throttle class and offset, final steering angle.
  typedef struct packed {
    logic               motor_active;
    logic               rev_sel;
    logic               below_min;
    logic [PULSE_W-1:0] diff;
    logic [7:0]         cap_prev;
    logic               steer_active;
    logic [7:0]         angle;
    logic [1:0]         led;
  } mid_t;

  typedef struct packed {
    logic       motor_update;
    logic       motor_enable;
    logic [7:0] pin_a_duty;
    logic [7:0] pin_b_duty;
    logic       steer_update;
    logic [7:0] steer_angle;
    logic [1:0] led_mode;
  } result_t;

endpackage

// File: rtl/core/rcpd_front.sv
// Front stage: throttle sample ring with running sum, battery store and level.
// Depends on rcpd_pkg.
module rcpd_front import rcpd_pkg::*; #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               accept,
  input  logic               load,
  input  logic [PULSE_W-1:0] throttle_pulse_us,
  input  logic [PULSE_W-1:0] steering_pulse_us,
  input  logic [BATT_W-1:0]  battery_raw,
  input  logic               battery_valid,
  output front_t             front_r
);

  localparam int PTR_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SAMPLE_COUNT - 1);

  logic [PULSE_W-1:0] ring_r [SAMPLE_COUNT];
  logic [PTR_W-1:0]   pos_r, pos_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [BATT_W-1:0]  batt_r, batt_nxt;
  logic [7:0]         cap_r, cap_nxt;
  logic [1:0]         led_nxt;
  front_t             front_nxt;

  always_comb begin
    sum_nxt  = sum_r - SUM_W'(ring_r[pos_r]) + SUM_W'(throttle_pulse_us);
    pos_nxt  = (pos_r == PTR_LAST) ? '0 : pos_r + 1'b1;
    batt_nxt = battery_valid ? battery_raw : batt_r;
    // Critical is tested first so that a misordered threshold set still caps hard.
    if (batt_nxt < cfg.battery_critical_raw) begin
      cap_nxt = CAP_CRIT;
      led_nxt = LED_BLINK;
    end else if (batt_nxt < cfg.battery_low_raw) begin
      cap_nxt = CAP_LOW;
      led_nxt = LED_BLINK;
    end else if (batt_nxt < cfg.battery_warn_raw) begin
      cap_nxt = CAP_WARN;
      led_nxt = LED_STEADY;
    end else begin
      cap_nxt = CAP_FULL;
      led_nxt = LED_OFF;
    end
    front_nxt.sum      = sum_nxt;
    front_nxt.thr_nz   = (throttle_pulse_us != '0);
    front_nxt.str      = steering_pulse_us;
    front_nxt.cap_prev = cap_r;
    front_nxt.led      = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        ring_r[i] <= '0;
      end
      pos_r  <= '0;
      sum_r  <= '0;
      batt_r <= '0;
      cap_r  <= CAP_FULL;
    end else if (accept) begin
      ring_r[pos_r] <= throttle_pulse_us;
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      batt_r <= batt_nxt;
      cap_r  <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_r <= front_nxt;
    end
  end

endmodule

// File: rtl/core/rcpd_mid.sv
// Middle stage: ring average by reciprocal multiply, throttle classification
// and the steering deadband and angle map. Depends on rcpd_pkg.
module rcpd_mid import rcpd_pkg::*; #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic   clk,
  input  cfg_t   cfg,
  input  logic   load,
  input  front_t front_in,
  output mid_t   mid_r
);

  // Exact floor division of a 16-bit sum: ceil(2^(16+l)/N) with l = ceil(log2 N).
  localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int AVG_MUL_W = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(
    ((64'd1 << AVG_SHIFT) + longint'(SAMPLE_COUNT) - 64'd1) / longint'(SAMPLE_COUNT));
  localparam int STR_PROD_W = PULSE_W + STR_K_W;

  logic [AVG_PROD_W-1:0] avg_prod;
  logic [PULSE_W-1:0]    avg;
  logic [PULSE_W-1:0]    thr_lo, thr_hi, str_lo, str_hi, str_off;
  logic                  rev_sel, fwd_sel, centered;
  logic [STR_PROD_W-1:0] str_prod;
  logic [8:0]            str_q;
  logic [9:0]            angle_raw;
  mid_t                  mid_nxt;

  always_comb begin
    avg_prod = AVG_PROD_W'(front_in.sum) * AVG_PROD_W'(AVG_MUL);
    avg      = avg_prod[AVG_SHIFT +: PULSE_W];
    thr_lo   = THR_NEUTRAL - PULSE_W'(cfg.throttle_deadband);
    thr_hi   = THR_NEUTRAL + PULSE_W'(cfg.throttle_deadband);
    rev_sel  = (avg < thr_lo);
    fwd_sel  = (avg > thr_hi);

    str_lo    = STR_NEUTRAL - PULSE_W'(cfg.steering_deadband);
    str_hi    = STR_NEUTRAL + PULSE_W'(cfg.steering_deadband);
    centered  = (front_in.str < str_hi) && (front_in.str > str_lo);
    str_off   = front_in.str - STR_MIN;
    str_prod  = STR_PROD_W'(str_off) * STR_PROD_W'(STR_K);
    str_q     = str_prod[RECIP_SHIFT +: 9];
    angle_raw = 10'(str_q) + 10'(ANGLE_MIN);

    mid_nxt.motor_active = front_in.thr_nz && (rev_sel || fwd_sel);
    mid_nxt.rev_sel      = rev_sel;
    mid_nxt.below_min    = (avg < THR_MIN);
    mid_nxt.diff         = rev_sel ? (avg - THR_MIN) : (avg - THR_NEUTRAL);
    mid_nxt.cap_prev     = front_in.cap_prev;
    mid_nxt.steer_active = !centered;
    mid_nxt.led          = front_in.led;
    if (centered) begin
      mid_nxt.angle = ANGLE_CENTER;
    end else if (front_in.str < STR_MIN) begin
      mid_nxt.angle = ANGLE_MIN;
    end else if (angle_raw > 10'(ANGLE_MAX)) begin
      mid_nxt.angle = ANGLE_MAX;
    end else begin
      mid_nxt.angle = angle_raw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

// File: rtl/core/rcpd_back.sv
// Back stage: duty map, battery cap, bridge pin routing and update counters,
// ending in the result register. Depends on rcpd_pkg.
module rcpd_back import rcpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    load,
  input  logic    advance,
  input  mid_t    mid_in,
  output result_t result_r
);

  localparam int DUTY_PROD_W = PULSE_W + THR_K_W;

  logic [THR_K_W-1:0]     duty_k;
  logic [DUTY_PROD_W-1:0] duty_prod;
  logic [PULSE_W-1:0]     duty_q;
  logic [7:0]             rev_duty, fwd_duty, duty, capped;
  logic [7:0]             pin_a, pin_b;
  logic [CNT_W-1:0]       mcnt_r, mcnt_nxt, mcnt_eff;
  logic [CNT_W-1:0]       scnt_r, scnt_nxt, scnt_eff;
  logic                   mupd, supd;
  result_t                result_nxt;

  always_comb begin
    // Only one direction is ever live, so one multiplier serves both maps.
    duty_k    = mid_in.rev_sel ? REV_K : FWD_K;
    duty_prod = DUTY_PROD_W'(mid_in.diff) * DUTY_PROD_W'(duty_k);
    duty_q    = duty_prod[RECIP_SHIFT +: PULSE_W];
    rev_duty  = mid_in.below_min ? CAP_FULL : 8'(PULSE_W'(CAP_FULL) - duty_q);
    fwd_duty  = (duty_q > PULSE_W'(CAP_FULL)) ? CAP_FULL : duty_q[7:0];
    duty      = mid_in.rev_sel ? rev_duty : fwd_duty;
    capped    = (duty < mid_in.cap_prev) ? duty : mid_in.cap_prev;

    pin_a = '0;
    pin_b = '0;
    if (mid_in.motor_active) begin
      if (mid_in.rev_sel ^ cfg.invert_motor) begin
        pin_b = capped;
      end else begin
        pin_a = capped;
      end
    end

    mcnt_eff = mid_in.motor_active ? '0 : mcnt_r;
    mupd     = (mcnt_eff < SEND_LIMIT);
    mcnt_nxt = mupd ? mcnt_eff + 1'b1 : mcnt_eff;
    scnt_eff = mid_in.steer_active ? '0 : scnt_r;
    supd     = (scnt_eff < SEND_LIMIT);
    scnt_nxt = supd ? scnt_eff + 1'b1 : scnt_eff;

    result_nxt.motor_update = mupd;
    result_nxt.motor_enable = mupd && mid_in.motor_active;
    result_nxt.pin_a_duty   = mupd ? pin_a : '0;
    result_nxt.pin_b_duty   = mupd ? pin_b : '0;
    result_nxt.steer_update = supd;
    result_nxt.steer_angle  = supd ? mid_in.angle : ANGLE_CENTER;
    result_nxt.led_mode     = mid_in.led;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
      scnt_r <= '0;
    end else if (advance) begin
      mcnt_r <= mcnt_nxt;
      scnt_r <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

endmodule

// File: rtl/core/rc_pulse_to_motor_servo_drive_unit.sv
// RC pulse to motor and servo drive, top level.
// Built from rcpd_front, rcpd_mid and rcpd_back; depends on rcpd_pkg.
//
// The in_ channel carries one measured throttle and steering pulse pair per
// item, with an optional fresh battery reading flagged in in_tuser. The out_
// channel returns exactly one result item per input item, in order: update
// flags in out_tuser, bridge enable, pin duties, servo angle and LED mode in
// out_tdata. The user writes registers via cfg_we/cfg_index/cfg_wdata only
// while the block is idle, not enforced; indexes past the last one are ignored.
//
// Each item passes three register stages from acceptance to out_tvalid: the
// ring update, the averaging multiply and the duty multiply each end in one. One
// item is accepted per cycle while in_tready is high. The battery cap applied
// to an item is the one left by the item before it.
//
// Synchronous reset clears the sample ring, sum, stored battery, update counters
// and stage valid bits and loads the register defaults; no clearing pass runs.
// When out_tready is low the result stays put and the stages behind it fill;
// in_tready drops once all three stages hold an item.
module rc_pulse_to_motor_servo_drive_unit import rcpd_pkg::*; #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] throttle_pulse_us, [23:12] steering_pulse_us, [33:24] battery_raw
  input  logic [39:0]           in_tdata,
  // [0] battery_valid
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] motor_enable, [8:1] pin_a_duty, [16:9] pin_b_duty,
  // [24:17] steer_angle, [26:25] led_mode
  output logic [31:0]           out_tdata,
  // [0] motor_update, [1] steer_update
  output logic [1:0]            out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    v1_r, v2_r, vout_r;
  logic    rdy1, rdy2, rdy_out, accept;
  front_t  front_q;
  mid_t    mid_q;
  result_t result_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_motor         <= 1'b1;
      cfg_r.throttle_deadband    <= DEADBAND_RST;
      cfg_r.steering_deadband    <= DEADBAND_RST;
      cfg_r.battery_warn_raw     <= BATT_WARN_RST;
      cfg_r.battery_low_raw      <= BATT_LOW_RST;
      cfg_r.battery_critical_raw <= BATT_CRIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INVERT_MOTOR: cfg_r.invert_motor         <= cfg_wdata[0];
        CFG_THR_DEADBAND: cfg_r.throttle_deadband    <= cfg_wdata[7:0];
        CFG_STR_DEADBAND: cfg_r.steering_deadband    <= cfg_wdata[7:0];
        CFG_BATT_WARN:    cfg_r.battery_warn_raw     <= cfg_wdata;
        CFG_BATT_LOW:     cfg_r.battery_low_raw      <= cfg_wdata;
        CFG_BATT_CRIT:    cfg_r.battery_critical_raw <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or the stage ahead of it moves on.
  assign rdy_out   = !vout_r || out_tready;
  assign rdy2      = !v2_r || rdy_out;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign accept    = in_tvalid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy_out) begin
        vout_r <= v2_r;
      end
    end
  end

  rcpd_front #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .accept            (accept),
    .load              (rdy1),
    .throttle_pulse_us (in_tdata[11:0]),
    .steering_pulse_us (in_tdata[23:12]),
    .battery_raw       (in_tdata[33:24]),
    .battery_valid     (in_tuser[0]),
    .front_r           (front_q)
  );

  rcpd_mid #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_mid (
    .clk      (clk),
    .cfg      (cfg_r),
    .load     (rdy2),
    .front_in (front_q),
    .mid_r    (mid_q)
  );

  rcpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .load     (rdy_out),
    .advance  (rdy_out && v2_r),
    .mid_in   (mid_q),
    .result_r (result_q)
  );

  assign out_tvalid = vout_r;
  assign out_tdata  = {5'b0, result_q.led_mode, result_q.steer_angle,
                       result_q.pin_b_duty, result_q.pin_a_duty, result_q.motor_enable};
  assign out_tuser  = {result_q.steer_update, result_q.motor_update};

endmodule

// File: rtl/core/rcpd_checker.sv
// Port-level checks on the result channel of the drive unit, and the bind that
// attaches them to the top level. Depends on nothing else.
module rcpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Without a motor update the bridge fields must all read zero.
  a_motor_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[16:0] == 17'd0)
    else $error("motor fields set without motor update");

  // A disabled bridge never drives either pin.
  a_bridge_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == 16'd0)
    else $error("pin duty set with bridge disabled");

  a_steer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[24:17] == 8'd90)
    else $error("steer angle off center without steer update");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[24:17] >= 8'd40 && out_tdata[24:17] <= 8'd140
                   && out_tdata[26:25] != 2'd3)
    else $error("angle or LED mode out of range");

endmodule

bind rc_pulse_to_motor_servo_drive_unit rcpd_checker u_rcpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/rc_pulse_to_motor_servo_drive_unit_tb.sv
// Self-checking bench for rc_pulse_to_motor_servo_drive_unit: directed pulse table,
// then random pulse runs under several register settings, each result checked
// against a known value or the drive predictor. Depends on rcpd_pkg and the RTL only.
module rc_pulse_to_motor_servo_drive_unit_tb;
  import rcpd_pkg::*;

  localparam int RING_DEPTH = 10;
  localparam int HALF_PERIOD = 6;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 92;

  // Drive constants, microseconds and degrees.
  localparam int unsigned T_MID = 1470;
  localparam int unsigned T_LO = 975;
  localparam int unsigned T_HI = 1967;
  localparam int unsigned S_MID = 1410;
  localparam int unsigned S_LO = 1000;
  localparam int unsigned S_HI = 1946;
  localparam int unsigned DEG_LO = 40;
  localparam int unsigned DEG_HI = 140;
  localparam int unsigned DEG_MID = 90;
  localparam int unsigned DUTY_FULL = 255;
  localparam int unsigned DUTY_WARN = 200;
  localparam int unsigned DUTY_LOW = 50;
  localparam int unsigned UPDATE_LIMIT = 10;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;

  typedef struct packed {
    logic       motor_update;
    logic       motor_enable;
    logic [7:0] pin_a;
    logic [7:0] pin_b;
    logic       steer_update;
    logic [7:0] angle;
    logic [1:0] led;
  } drive_out_t;

  typedef struct packed {
    logic [11:0] thr;
    logic [11:0] str;
    logic [9:0]  batt;
    logic        batt_fresh;
    bit          known;
    drive_out_t  want;
  } pulse_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor copy of registers and state.
  logic        inv_q;
  int unsigned thr_band_q, str_band_q, warn_q, low_q, crit_q;
  int unsigned thr_ring[RING_DEPTH];
  int unsigned ring_idx, ring_total, batt_seen, duty_cap, motor_sends, steer_sends;

  drive_out_t  pending_q[$];
  pulse_row_t  pulse_table[$];
  bit          calm;
  int          faults;
  int          mismatches;
  int          results_seen;

  rc_pulse_to_motor_servo_drive_unit #(
    .SAMPLE_COUNT(RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #(2 * HALF_PERIOD * 300000);
    $display("rc_pulse_to_motor_servo_drive_unit test failed");
    $finish;
  end

  function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic drive_out_t predict_drive(input logic [11:0] thr, input logic [11:0] str,
                                               input logic [9:0] batt, input logic fresh);
    int unsigned t, s, avg, duty, fwd, rev, ang, pa, pb;
    logic        en;
    logic [1:0]  led;
    drive_out_t  r;
    t = 32'(thr);
    s = 32'(str);
    fwd = 0;
    rev = 0;
    en = 1'b0;
    ring_total = (ring_total - thr_ring[ring_idx] + t) & 32'hFFFF;
    thr_ring[ring_idx] = t;
    ring_idx = (ring_idx + 1 >= RING_DEPTH) ? 0 : ring_idx + 1;
    avg = ring_total / RING_DEPTH;

    // The cap used here is the one left behind by the previous item.
    if (t != 0) begin
      if (avg < T_MID - thr_band_q) begin
        duty = (avg < T_LO) ? DUTY_FULL : DUTY_FULL - ((avg - T_LO) * 255) / (T_MID - T_LO);
        rev = min_u(duty, duty_cap);
        en = 1'b1;
        motor_sends = 0;
      end else if (avg > T_MID + thr_band_q) begin
        duty = ((avg - T_MID) * 255) / (T_HI - T_MID);
        fwd = min_u(duty, duty_cap);
        en = 1'b1;
        motor_sends = 0;
      end
    end

    if (s < S_MID + str_band_q && s > S_MID - str_band_q) begin
      ang = DEG_MID;
    end else begin
      ang = (s < S_LO) ? DEG_LO : min_u(DEG_LO + ((s - S_LO) * 100) / (S_HI - S_LO), DEG_HI);
      steer_sends = 0;
    end

    if (fresh)
      batt_seen = 32'(batt);
    if (batt_seen < crit_q) begin
      duty_cap = 0;
      led = LED_BLINK;
    end else if (batt_seen < low_q) begin
      duty_cap = DUTY_LOW;
      led = LED_BLINK;
    end else if (batt_seen < warn_q) begin
      duty_cap = DUTY_WARN;
      led = LED_STEADY;
    end else begin
      duty_cap = DUTY_FULL;
      led = LED_OFF;
    end

    pa = 0;
    pb = 0;
    if (en && fwd > 0) begin
      if (inv_q) pb = fwd;
      else pa = fwd;
    end else if (en && rev > 0) begin
      if (inv_q) pa = rev;
      else pb = rev;
    end

    r.motor_update = (motor_sends < UPDATE_LIMIT);
    if (r.motor_update)
      motor_sends++;
    r.steer_update = (steer_sends < UPDATE_LIMIT);
    if (r.steer_update)
      steer_sends++;
    r.motor_enable = r.motor_update ? en : 1'b0;
    r.pin_a = r.motor_update ? pa[7:0] : 8'd0;
    r.pin_b = r.motor_update ? pb[7:0] : 8'd0;
    r.angle = r.steer_update ? ang[7:0] : DEG_MID[7:0];
    r.led = led;
    return r;
  endfunction

  task automatic clear_predictor();
    inv_q = 1'b1;
    thr_band_q = 30;
    str_band_q = 30;
    warn_q = 737;
    low_q = 696;
    crit_q = 655;
    foreach (thr_ring[i])
      thr_ring[i] = 0;
    ring_idx = 0;
    ring_total = 0;
    batt_seen = 0;
    duty_cap = DUTY_FULL;
    motor_sends = 0;
    steer_sends = 0;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_INVERT_MOTOR: inv_q = val[0];
      CFG_THR_DEADBAND: thr_band_q = 32'(val[7:0]);
      CFG_STR_DEADBAND: str_band_q = 32'(val[7:0]);
      CFG_BATT_WARN:    warn_q = 32'(val);
      CFG_BATT_LOW:     low_q = 32'(val);
      CFG_BATT_CRIT:    crit_q = 32'(val);
      default: ;
    endcase
  endtask

  // Stops offering items and waits until every expected result is back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_regs(input logic inv, input logic [CFG_DATA_W-1:0] tband,
                           input logic [CFG_DATA_W-1:0] sband, input logic [CFG_DATA_W-1:0] warn,
                           input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] crit);
    settle();
    put_reg(CFG_INVERT_MOTOR, {9'd0, inv});
    put_reg(CFG_THR_DEADBAND, tband);
    put_reg(CFG_STR_DEADBAND, sband);
    put_reg(CFG_BATT_WARN, warn);
    put_reg(CFG_BATT_LOW, low);
    put_reg(CFG_BATT_CRIT, crit);
    put_reg($urandom_range(0, 1) ? SPARE_IDX_A : SPARE_IDX_B, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic offer_pulse(input pulse_row_t row);
    drive_out_t guess;
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, row.batt, row.str, row.thr};
    in_tuser <= row.batt_fresh;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    guess = predict_drive(row.thr, row.str, row.batt, row.batt_fresh);
    pending_q.push_back(row.known ? row.want : guess);
  endtask

  task automatic add_row(input logic [11:0] thr, input logic [11:0] str,
                         input logic [9:0] batt, input logic fresh);
    pulse_row_t row;
    row = '0;
    row.thr = thr;
    row.str = str;
    row.batt = batt;
    row.batt_fresh = fresh;
    pulse_table.push_back(row);
  endtask

  task automatic add_known(input logic [11:0] thr, input logic [11:0] str,
                           input logic [9:0] batt, input logic fresh, input drive_out_t want);
    pulse_row_t row;
    row.thr = thr;
    row.str = str;
    row.batt = batt;
    row.batt_fresh = fresh;
    row.known = 1'b1;
    row.want = want;
    pulse_table.push_back(row);
  endtask

  // Random pulses come in runs of one kind: plausible stick positions, sticks
  // resting in the neutral bands (so the update counts run out), lost throttle
  // pulses, and raw noise over the whole field range.
  task automatic drive_random(input int count);
    int          kind, run_left;
    int unsigned lo, hi;
    pulse_row_t  row;
    run_left = 0;
    kind = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        kind = $urandom_range(0, 99);
        run_left = $urandom_range(1, 14);
      end
      run_left--;
      row = '0;
      if (kind < 55) begin
        row.thr = 12'($urandom_range(900, 2050));
        row.str = 12'($urandom_range(950, 2000));
      end else if (kind < 72) begin
        row.thr = 12'($urandom_range(T_MID - thr_band_q, T_MID + thr_band_q));
        lo = (str_band_q > 1) ? S_MID - str_band_q + 1 : S_MID;
        hi = (str_band_q > 1) ? S_MID + str_band_q - 1 : S_MID;
        row.str = 12'($urandom_range(lo, hi));
      end else if (kind < 84) begin
        row.thr = 12'd0;
        row.str = 12'($urandom_range(900, 2050));
      end else begin
        row.thr = 12'($urandom);
        row.str = 12'($urandom);
      end
      row.batt = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(600, 800));
      row.batt_fresh = ($urandom_range(0, 2) == 0);
      offer_pulse(row);
    end
  endtask

  task automatic check_result(input drive_out_t got);
    drive_out_t want;
    if (pending_q.size() == 0) begin
      faults++;
      $display("unexpected result item: %p", got);
    end else begin
      want = pending_q.pop_front();
      if (got !== want) begin
        faults++;
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch at result %0d: exp mu=%0b en=%0b a=%0d b=%0d su=%0b ang=%0d led=%0d",
                 results_seen, want.motor_update, want.motor_enable, want.pin_a,
                 want.pin_b, want.steer_update, want.angle, want.led);
          $display(", got mu=%0b en=%0b a=%0d b=%0d su=%0b ang=%0d led=%0d",
                   got.motor_update, got.motor_enable, got.pin_a, got.pin_b,
                   got.steer_update, got.angle, got.led);
        end
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off that lets the block
  // fill up and push back on its input.
  initial begin
    int  hold_left;
    bit  hold_done;
    drive_out_t got;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        got.motor_update = out_tuser[0];
        got.steer_update = out_tuser[1];
        got.motor_enable = out_tdata[0];
        got.pin_a = out_tdata[8:1];
        got.pin_b = out_tdata[16:9];
        got.angle = out_tdata[24:17];
        got.led = out_tdata[26:25];
        check_result(got);
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    faults = 0;
    mismatches = 0;
    results_seen = 0;
    clear_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Just after reset: no pulse, steering far below range, full battery.
    add_known(12'd0, 12'd0, 10'd1023, 1'b1,
              drive_out_t'({1'b1, 1'b0, 8'd0, 8'd0, 1'b1, 8'd40, LED_OFF}));
    // Saturated pulses: full reverse on the swapped pin, steering clamped.
    add_known(12'd4095, 12'd4095, 10'd0, 1'b0,
              drive_out_t'({1'b1, 1'b1, 8'd255, 8'd0, 1'b1, 8'd140, LED_OFF}));
    // Empty battery reading: critical level, cap takes effect one item later.
    add_known(12'd1470, 12'd1410, 10'd0, 1'b1,
              drive_out_t'({1'b1, 1'b1, 8'd255, 8'd0, 1'b1, 8'd90, LED_BLINK}));
    // Zero cap: bridge enabled with both pins at zero.
    add_known(12'd4095, 12'd1410, 10'd0, 1'b0,
              drive_out_t'({1'b1, 1'b1, 8'd0, 8'd0, 1'b1, 8'd90, LED_BLINK}));
    add_row(12'd4095, 12'd1946, 10'd737, 1'b1);
    add_row(12'd4095, 12'd1947, 10'd0, 1'b0);
    add_row(12'd4095, 12'd999, 10'd0, 1'b0);
    // Lost throttle pulses with steering at rest: both update counts run out
    // while the battery walks across every level boundary.
    add_row(12'd0, 12'd1410, 10'd654, 1'b1);
    add_row(12'd0, 12'd1410, 10'd655, 1'b1);
    add_row(12'd0, 12'd1410, 10'd695, 1'b1);
    add_row(12'd0, 12'd1410, 10'd696, 1'b1);
    add_row(12'd0, 12'd1410, 10'd736, 1'b1);
    add_row(12'd0, 12'd1410, 10'd737, 1'b1);
    add_row(12'd0, 12'd1381, 10'd1023, 1'b0);
    add_row(12'd0, 12'd1439, 10'd0, 1'b0);
    add_row(12'd0, 12'd1410, 10'd0, 1'b0);
    add_row(12'd0, 12'd1410, 10'd0, 1'b0);
    add_row(12'd0, 12'd1410, 10'd0, 1'b0);
    add_row(12'd0, 12'd1410, 10'd0, 1'b0);
    add_row(12'd0, 12'd1380, 10'd1023, 1'b1);
    add_row(12'd0, 12'd1440, 10'd0, 1'b0);
    add_row(12'd1, 12'd1000, 10'd0, 1'b0);
    add_row(12'd1967, 12'd1946, 10'd1023, 1'b1);
    add_row(12'd1500, 12'd1410, 10'd512, 1'b1);
    add_row(12'd975, 12'd2048, 10'd0, 1'b0);
    foreach (pulse_table[i])
      offer_pulse(pulse_table[i]);

    load_regs(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    drive_random(ITEMS_PER_PHASE);
    load_regs(1'b1, 10'd255, 10'd255, 10'd1023, 10'd1023, 10'd1023);
    drive_random(ITEMS_PER_PHASE);
    // Thresholds out of order: critical still wins over low and warning.
    load_regs(1'($urandom_range(0, 1)), 10'($urandom), 10'($urandom),
              10'd600, 10'd700, 10'd650);
    drive_random(ITEMS_PER_PHASE);
    calm = 1'b1;
    load_regs(1'($urandom_range(0, 1)), 10'($urandom_range(0, 255)),
              10'($urandom_range(0, 255)), 10'($urandom_range(640, 760)),
              10'($urandom_range(640, 760)), 10'($urandom_range(640, 760)));
    drive_random(ITEMS_PER_PHASE);
    calm = 1'b0;
    load_regs(1'($urandom_range(0, 1)), 10'($urandom), 10'($urandom), 10'($urandom),
              10'($urandom), 10'($urandom));
    drive_random(ITEMS_PER_PHASE);
    load_regs(1'b1, 10'd30, 10'd30, 10'd737, 10'd696, 10'd655);
    drive_random(ITEMS_PER_PHASE);

    settle();
    repeat (8) @(posedge clk);
    if (pending_q.size() != 0) begin
      faults++;
      $display("%0d expected result items never arrived", pending_q.size());
    end
    if (faults == 0)
      $display("rc_pulse_to_motor_servo_drive_unit test passed");
    else
      $display("rc_pulse_to_motor_servo_drive_unit test failed");
    $finish;
  end

endmodule
